>>> hw/rtl/fdnm_pkg.sv
`default_nettype none

package fdnm_pkg;

	// item kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_NAME  = 2'd1;
	localparam logic [1:0] KIND_ENTRY = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// result status codes
	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_END_MARK = 2'd1;
	localparam logic [1:0] ST_SCANNED  = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	// 8.3 name layout
	localparam int NAME_LEN = 11;
	localparam int EXT_POS  = 8;
	localparam int POS_W    = 4;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;
	localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_DIFF  = 8'h20;
	localparam logic [7:0] ATTR_SKIP  = 8'h18;

	// directory size and entry counter width (holds ENTRY_COUNT itself)
	localparam int ENTRY_COUNT = 256;
	localparam int IDX_W       = $clog2(ENTRY_COUNT + 1);

	typedef logic [7:0] byte_t;

	// one item after the lane compare
	typedef struct packed {
		logic [1:0]          kind;
		logic                too_long;
		logic                end_mark;
		logic                attr_ok;
		logic [NAME_LEN-1:0] lane_eq;
		logic                last;
	} fdnm_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/fat_directory_name_match_unit.sv
`default_nettype none

// FAT 8.3 directory name lookup. Send a start beat, then the file name one byte
// per beat, then directory entries one per beat; one result (found with index,
// end marker, all scanned, or name too long) comes out per search, later beats
// are dropped until the next start. A new beat can be taken each cycle unless the
// input stalls as told below: eleven byte lanes hold the kept name and compare it with the
// entry as it is accepted, a registered stage carries the lane results, and a
// merge stage updates the entry counter and fills the output register, so a
// result is presented once its beat has passed the stage-1 register and then the output register.
// A beat that ends a search waits in the registered stage while the previous
// result is still held in the output register, and the input stalls behind it;
// all other beats pass. Up to 256 entries per search.
module fat_directory_name_match_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [1:0]  kind,
	input  wire [7:0]  name_char,
	input  wire [63:0] entry_base,
	input  wire [23:0] entry_ext,
	input  wire [7:0]  entry_attr,
	input  wire        last_entry,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [1:0] status,
	output logic [7:0] entry_index
);
	import fdnm_pkg::*;

	logic             in_acc;
	logic             take;
	logic [POS_W-1:0] pos_q;
	logic             valid_s1;
	fdnm_item_t       item_s1;
	fdnm_item_t       item_in;
	byte_t            upper_char;
	byte_t            entry_bytes [NAME_LEN];
	logic             name_clear;
	logic             name_beat;
	logic             pos_full;
	logic             dot_jump;
	logic             name_wr;
	logic [NAME_LEN-1:0] lane_eq;

	assign in_ready = !valid_s1 || take;
	assign in_acc   = in_valid && in_ready;

	// split the entry into its eleven name bytes
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			entry_bytes[i] = entry_base[8*i +: 8];
		end
		for (int i = 0; i < 3; i++) begin
			entry_bytes[EXT_POS + i] = entry_ext[8*i +: 8];
		end
	end

	// normalize the name byte
	assign upper_char = (name_char >= CHAR_LOW_A && name_char <= CHAR_LOW_Z) ?
		(name_char - CASE_DIFF) : name_char;
	assign name_clear = in_acc && (kind == KIND_START);
	assign name_beat  = in_acc && (kind == KIND_NAME) && (name_char != CHAR_NUL);
	assign pos_full   = (pos_q >= POS_W'(NAME_LEN));
	assign dot_jump   = (name_char == CHAR_DOT) && (pos_q <= POS_W'(EXT_POS));
	assign name_wr    = name_beat && !pos_full && !dot_jump;

	// advance the write position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (name_clear) begin
			pos_q <= '0;
		end else if (name_beat && !pos_full) begin
			pos_q <= dot_jump ? POS_W'(EXT_POS) : (pos_q + POS_W'(1));
		end
	end

	// byte lanes
	for (genvar i = 0; i < NAME_LEN; i++) begin : g_lane
		fdnm_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.clear      (name_clear),
			.wr_en      (name_wr && (pos_q == POS_W'(i))),
			.wr_byte    (upper_char),
			.entry_byte (entry_bytes[i]),
			.eq         (lane_eq[i])
		);
	end

	always_comb begin
		item_in.kind     = kind;
		item_in.too_long = (name_char != CHAR_NUL) && pos_full;
		item_in.end_mark = (entry_base[7:0] == CHAR_NUL);
		item_in.attr_ok  = ((entry_attr & ATTR_SKIP) == 8'd0);
		item_in.lane_eq  = lane_eq;
		item_in.last     = last_entry;
	end

	// stage 1: hold the compared beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item_in;
		end
	end

	fdnm_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.s1_valid    (valid_s1),
		.s1_item     (item_s1),
		.take        (take),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.status      (status),
		.entry_index (entry_index)
	);

endmodule

`default_nettype wire

>>> hw/rtl/fdnm_lane.sv
`default_nettype none

module fdnm_lane (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               clear,
	input  wire               wr_en,
	input  wire fdnm_pkg::byte_t wr_byte,
	input  wire fdnm_pkg::byte_t entry_byte,
	output logic              eq
);
	import fdnm_pkg::*;

	byte_t name_q;

	// hold one byte of the kept name; space after clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_q <= CHAR_SPACE;
		end else if (clear) begin
			name_q <= CHAR_SPACE;
		end else if (wr_en) begin
			name_q <= wr_byte;
		end
	end

	// compare against the entry byte of this lane
	assign eq = (entry_byte == name_q);

endmodule

`default_nettype wire

>>> hw/rtl/fdnm_merge.sv
`default_nettype none

module fdnm_merge (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s1_valid,
	input  wire fdnm_pkg::fdnm_item_t s1_item,
	output logic                 take,
	input  wire                  out_ready,
	output logic                 out_valid,
	output logic [1:0]           status,
	output logic [7:0]           entry_index
);
	import fdnm_pkg::*;

	logic             done_q;
	logic [IDX_W-1:0] scan_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [7:0]       index_q;

	logic             emit;
	logic [1:0]       emit_status;
	logic             name_hit;
	logic [IDX_W-1:0] scan_next;
	logic [IDX_W+7:0] scan_wide;

	// stall only a beat that has a result to place in a full output register
	assign take      = s1_valid && (!emit || !out_valid_q || out_ready);
	assign name_hit  = s1_item.attr_ok && (&s1_item.lane_eq);
	assign scan_next = scan_q + IDX_W'(1);
	assign scan_wide = {8'd0, scan_q};

	// decide whether this beat ends the search
	always_comb begin
		emit        = 1'b0;
		emit_status = ST_FOUND;
		if (!done_q) begin
			case (s1_item.kind)
				KIND_NAME: begin
					if (s1_item.too_long) begin
						emit        = 1'b1;
						emit_status = ST_TOO_LONG;
					end
				end
				KIND_ENTRY: begin
					if (s1_item.end_mark) begin
						emit        = 1'b1;
						emit_status = ST_END_MARK;
					end else if (name_hit) begin
						emit        = 1'b1;
						emit_status = ST_FOUND;
					end else if (s1_item.last ||
						scan_next >= IDX_W'(ENTRY_COUNT)) begin
						emit        = 1'b1;
						emit_status = ST_SCANNED;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	// advance search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			scan_q <= '0;
		end else if (take) begin
			if (s1_item.kind == KIND_START) begin
				done_q <= 1'b0;
				scan_q <= '0;
			end else begin
				if (emit) begin
					done_q <= 1'b1;
				end
				if (!done_q && s1_item.kind == KIND_ENTRY && !s1_item.end_mark &&
					!name_hit) begin
					scan_q <= scan_next;
				end
			end
		end
	end

	// hold the result until the output side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			status_q <= emit_status;
			index_q  <= (emit_status == ST_FOUND) ? scan_wide[7:0] : 8'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_index = index_q;

`ifndef SYNTHESIS
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_FOUND |-> index_q == 8'd0)
		else $error("entry_index nonzero without a match");
	a_done_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit |=> done_q)
		else $error("search not closed after a result");
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !emit)
		else $error("second result in one search");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q |-> scan_q < IDX_W'(ENTRY_COUNT))
		else $error("entry counter past directory size while searching");
`endif

endmodule

`default_nettype wire
